[rtl/qte_pkg.sv]
// shared types, constants and the arctangent table of the quaternion to euler angle unit
`default_nettype none
package qte_pkg;

    localparam int IN_WIDTH          = 16;
    localparam int FRAC_BITS         = 28;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ARC_LEN           = 24;
    localparam int SUM_W             = 36;
    localparam int VEC_W             = 38;
    localparam int ANG_W             = 30;
    localparam int RAD_W             = 58;
    localparam int SQ_N              = 29;
    localparam int PITCH_LIMIT       = 11520;
    localparam int TURN_LIMIT        = 23040;

    localparam logic signed [SUM_W-1:0] ONE_Q = SUM_W'(1) <<< FRAC_BITS;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(90) <<< 20;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] quat_w;
        logic signed [IN_WIDTH-1:0] quat_x;
        logic signed [IN_WIDTH-1:0] quat_y;
        logic signed [IN_WIDTH-1:0] quat_z;
    } t_quat_req;

    typedef struct packed {
        logic signed [14:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic signed [15:0] roll_angle;
        logic               pitch_saturated;
    } t_euler_res;

    // atan(2^-i) in units of 2^-20 degree, rounded to nearest
    function automatic logic signed [ANG_W-1:0] arc_angle(input int idx);
        logic signed [ANG_W-1:0] a;
        case (idx)
            0: a = ANG_W'(47185920);
            1: a = ANG_W'(27855475);
            2: a = ANG_W'(14718068);
            3: a = ANG_W'(7471121);
            4: a = ANG_W'(3750058);
            5: a = ANG_W'(1876857);
            6: a = ANG_W'(938658);
            7: a = ANG_W'(469357);
            8: a = ANG_W'(234682);
            9: a = ANG_W'(117342);
            10: a = ANG_W'(58671);
            11: a = ANG_W'(29335);
            12: a = ANG_W'(14668);
            13: a = ANG_W'(7334);
            14: a = ANG_W'(3667);
            15: a = ANG_W'(1833);
            16: a = ANG_W'(917);
            17: a = ANG_W'(458);
            18: a = ANG_W'(229);
            19: a = ANG_W'(115);
            20: a = ANG_W'(57);
            21: a = ANG_W'(29);
            22: a = ANG_W'(14);
            23: a = ANG_W'(7);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

[rtl/qte_cordic.sv]
// pipelined vectoring cordic: atan2(num, den) rounded to 1/128 degree and clamped
`default_nettype none
module qte_cordic
    import qte_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF,
    parameter int LIMIT  = TURN_LIMIT
) (
    input  wire logic                    i_clk,
    input  wire logic signed [VEC_W-1:0] i_num,
    input  wire logic signed [VEC_W-1:0] i_den,
    output logic signed [15:0]           o_angle
);

    logic signed [VEC_W-1:0] r_x    [0:STAGES];
    logic signed [VEC_W-1:0] r_y    [0:STAGES];
    logic signed [ANG_W-1:0] r_acc  [0:STAGES];
    logic                    r_zero [0:STAGES];

    logic signed [ANG_W-1:0] n_acc0;
    logic signed [VEC_W-1:0] n_x0;
    logic signed [VEC_W-1:0] n_y0;
    logic signed [31:0]      n_round;
    logic signed [31:0]      n_clamp;

    // fold the left half plane into the right one
    always_comb begin
        n_x0   = i_den;
        n_y0   = i_num;
        n_acc0 = '0;
        if (i_den < 0) begin
            if (i_num >= 0) begin
                n_x0   = i_num;
                n_y0   = -i_den;
                n_acc0 = QUARTER_TURN;
            end else begin
                n_x0   = -i_num;
                n_y0   = i_den;
                n_acc0 = -QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= n_x0;
        r_y[0]    <= n_y0;
        r_acc[0]  <= n_acc0;
        r_zero[0] <= (i_num == 0) && (i_den == 0);
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_iter
        always_ff @(posedge i_clk) begin
            r_zero[i+1] <= r_zero[i];
            if (r_y[i] >= 0) begin
                r_x[i+1]   <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1]   <= r_y[i] - (r_x[i] >>> i);
                r_acc[i+1] <= r_acc[i] + arc_angle(i);
            end else begin
                r_x[i+1]   <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1]   <= r_y[i] + (r_x[i] >>> i);
                r_acc[i+1] <= r_acc[i] - arc_angle(i);
            end
        end
    end

    always_comb begin
        n_round = (32'(r_acc[STAGES]) + 32'sd4096) >>> 13;
        if (n_round > 32'(LIMIT)) begin
            n_clamp = 32'(LIMIT);
        end else if (n_round < -32'(LIMIT)) begin
            n_clamp = -32'(LIMIT);
        end else begin
            n_clamp = n_round;
        end
    end

    always_ff @(posedge i_clk) begin
        o_angle <= r_zero[STAGES] ? 16'sd0 : 16'(n_clamp);
    end

    // x/y of the last stage do not feed the angle; only the direction bits of the earlier stages do
    logic unused_tail;
    assign unused_tail = ^{r_x[STAGES], r_y[STAGES]};

endmodule
`default_nettype wire

[rtl/quaternion_to_euler_angles_unit.sv]
// top level: unit quaternion in, pitch / yaw / roll in 1/128 degree out
// throughput: one request per cycle; busy is always low, the pipeline never stalls
// the pipeline length is set by the 29-step square root of the pitch path plus the cordic pipes
// reset (i_rst_n low, synchronous) clears only the valid bits; data registers are not reset
// o_done marks each result for exactly one cycle, the receiver cannot hold it off
`default_nettype none
module quaternion_to_euler_angles_unit
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire t_quat_req  i_req,
    output logic            o_done,
    output t_euler_res      o_res
);

    localparam int VLD_N = 3 + SQ_N + CORDIC_STAGES + 2;
    localparam int SAT_N = CORDIC_STAGES + 2;

    // values carried alongside the square root
    typedef struct packed {
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] rn;
        logic signed [SUM_W-1:0] rd;
        logic signed [SUM_W-1:0] yn;
        logic signed [SUM_W-1:0] yd;
        logic                    sat_pos;
        logic                    sat_neg;
    } t_mid;

    assign busy = 1'b0;

    // request valid travels with the data
    logic [VLD_N-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            o_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[VLD_N-2:0], start & ~busy};
            o_done <= r_vld[VLD_N-1];
        end
    end

    // stage 1: component products, all exact in Q.28
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_zz, r_wz, r_xy, r_wy, r_zx;
    always_ff @(posedge i_clk) begin
        r_wx <= i_req.quat_w * i_req.quat_x;
        r_yz <= i_req.quat_y * i_req.quat_z;
        r_xx <= i_req.quat_x * i_req.quat_x;
        r_yy <= i_req.quat_y * i_req.quat_y;
        r_zz <= i_req.quat_z * i_req.quat_z;
        r_wz <= i_req.quat_w * i_req.quat_z;
        r_xy <= i_req.quat_x * i_req.quat_y;
        r_wy <= i_req.quat_w * i_req.quat_y;
        r_zx <= i_req.quat_z * i_req.quat_x;
    end

    // stage 2: numerators and denominators of the three angles
    logic signed [SUM_W-1:0] r_rn, r_rd, r_yn, r_yd, r_s;
    always_ff @(posedge i_clk) begin
        r_rn <= (SUM_W'(r_wx) + SUM_W'(r_yz)) <<< 1;
        r_rd <= ONE_Q - ((SUM_W'(r_xx) + SUM_W'(r_yy)) <<< 1);
        r_yn <= (SUM_W'(r_wz) + SUM_W'(r_xy)) <<< 1;
        r_yd <= ONE_Q - ((SUM_W'(r_yy) + SUM_W'(r_zz)) <<< 1);
        r_s  <= (SUM_W'(r_wy) - SUM_W'(r_zx)) <<< 1;
    end

    // stage 3: gimbal lock test and radicand 1 - s^2 in Q.56
    logic signed [28:0]       n_s_lo;
    logic signed [RAD_W-1:0]  n_sq;
    logic [RAD_W-1:0]         r_rad;
    t_mid                     r_mid [0:SQ_N];

    assign n_s_lo = r_s[28:0];
    assign n_sq   = RAD_W'(n_s_lo * n_s_lo);

    always_ff @(posedge i_clk) begin
        r_rad            <= (RAD_W'(1) << (2 * FRAC_BITS)) - RAD_W'(n_sq);
        r_mid[0].s       <= r_s;
        r_mid[0].rn      <= r_rn;
        r_mid[0].rd      <= r_rd;
        r_mid[0].yn      <= r_yn;
        r_mid[0].yd      <= r_yd;
        r_mid[0].sat_pos <= r_s >= ONE_Q;
        r_mid[0].sat_neg <= r_s <= -ONE_Q;
    end

    // square root, one result bit per stage
    logic [RAD_W-1:0] r_sv [0:SQ_N-1];
    logic [RAD_W-1:0] r_sr [0:SQ_N-1];

    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (SQ_N - 1 - k));
        logic [RAD_W-1:0] v_in, res_in, trial;
        if (k == 0) begin : g_first
            assign v_in   = r_rad;
            assign res_in = '0;
        end else begin : g_next
            assign v_in   = r_sv[k-1];
            assign res_in = r_sr[k-1];
        end
        assign trial = res_in + BIT;
        always_ff @(posedge i_clk) begin
            r_mid[k+1] <= r_mid[k];
            if (v_in >= trial) begin
                r_sv[k] <= v_in - trial;
                r_sr[k] <= (res_in >> 1) + BIT;
            end else begin
                r_sv[k] <= v_in;
                r_sr[k] <= res_in >> 1;
            end
        end
    end

    // three cordic pipes side by side
    logic signed [15:0] pitch_ang, yaw_ang, roll_ang;

    qte_cordic #(.STAGES(CORDIC_STAGES), .LIMIT(PITCH_LIMIT)) u_pitch (
        .i_clk   (i_clk),
        .i_num   (VEC_W'(r_mid[SQ_N].s)),
        .i_den   ($signed(VEC_W'(r_sr[SQ_N-1][29:0]))),
        .o_angle (pitch_ang)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES), .LIMIT(TURN_LIMIT)) u_yaw (
        .i_clk   (i_clk),
        .i_num   (VEC_W'(r_mid[SQ_N].yn)),
        .i_den   (VEC_W'(r_mid[SQ_N].yd)),
        .o_angle (yaw_ang)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES), .LIMIT(TURN_LIMIT)) u_roll (
        .i_clk   (i_clk),
        .i_num   (VEC_W'(r_mid[SQ_N].rn)),
        .i_den   (VEC_W'(r_mid[SQ_N].rd)),
        .o_angle (roll_ang)
    );

    // gimbal lock flags follow the cordic latency
    logic [1:0] r_sat [0:SAT_N-1];
    always_ff @(posedge i_clk) begin
        r_sat[0] <= {r_mid[SQ_N].sat_pos, r_mid[SQ_N].sat_neg};
    end
    for (genvar j = 1; j < SAT_N; j++) begin : g_sat
        always_ff @(posedge i_clk) begin
            r_sat[j] <= r_sat[j-1];
        end
    end

    // output register; saturated pitch overrides the cordic result
    always_ff @(posedge i_clk) begin
        o_res.yaw_angle       <= yaw_ang;
        o_res.roll_angle      <= roll_ang;
        o_res.pitch_saturated <= |r_sat[SAT_N-1];
        if (r_sat[SAT_N-1][1]) begin
            o_res.pitch_angle <= 15'(PITCH_LIMIT);
        end else if (r_sat[SAT_N-1][0]) begin
            o_res.pitch_angle <= -15'(PITCH_LIMIT);
        end else begin
            o_res.pitch_angle <= pitch_ang[14:0];
        end
    end

    // remainder of the last root step and the unused bits are not needed
    logic unused_bits;
    assign unused_bits = ^{r_sv[SQ_N-1], r_sr[SQ_N-1][RAD_W-1:30], pitch_ang[15]};

endmodule
`default_nettype wire
